@@ design/jsu_pkg.sv @@
// shared types and codes of the json string unescaper
package jsu_pkg;

    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_ESC_END      = 4'd1;
    localparam logic [3:0] ERR_SHORT_UNI    = 4'd2;
    localparam logic [3:0] ERR_BAD_HEX      = 4'd3;
    localparam logic [3:0] ERR_NO_LOW       = 4'd4;
    localparam logic [3:0] ERR_BAD_LOW_HEX  = 4'd5;
    localparam logic [3:0] ERR_BAD_LOW      = 4'd6;
    localparam logic [3:0] ERR_BAD_ESC      = 4'd7;
    localparam logic [3:0] ERR_CTRL_CHAR    = 4'd8;
    localparam logic [3:0] ERR_UNTERMINATED = 4'd9;

    // results caused by one input byte: up to four utf-8 bytes, or one done/error result
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            has_byte;
        logic            done;
        logic [3:0]      err;
    } group_t;

endpackage

@@ design/jsu_if.sv @@
// stream interfaces for raw input bytes and decoded result items
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, data_byte, end_of_input, input ready);
    modport sink (input valid, data_byte, end_of_input, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       string_done;
    logic [3:0] error_code;
    logic       last;

    modport source (output valid, out_byte, has_byte, string_done, error_code, last,
                    input ready);
    modport sink (input valid, out_byte, has_byte, string_done, error_code, last,
                  output ready);
endinterface

@@ design/json_string_unescape_utf8.sv @@
// JSON string body unescaper: raw bytes in, UTF-8 bytes and done/error items out.
// One raw byte is taken per cycle when each yields at most one result and the output
// is ready. A byte that completes a \u escape yields one to four UTF-8 items, and the
// single result register hands them out one per cycle while the output is ready; the
// input waits meanwhile. Bytes that only advance an escape give no result; done and
// error items carry has_byte low and reset the decoder for the next string.
module json_string_unescape_utf8 (
    input  logic      clk,
    input  logic      rst_n,
    jsu_in_if.sink    in_ch,
    jsu_out_if.source out_ch
);

    jsu_pkg::group_t group;
    logic            free;
    logic            accept;

    assign in_ch.ready = free;
    assign accept      = in_ch.valid && free;

    jsu_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (in_ch.data_byte),
        .end_of_input (in_ch.end_of_input),
        .group        (group)
    );

    jsu_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .group  (group),
        .free   (free),
        .out_ch (out_ch)
    );

endmodule

@@ design/jsu_decode.sv @@
// escape state machine and utf-8 encoder for one raw byte
module jsu_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                end_of_input,
    output jsu_pkg::group_t     group
);

    typedef enum logic [2:0] {
        PH_BODY,
        PH_ESC,
        PH_HEX_HIGH,
        PH_WANT_BSL,
        PH_WANT_U,
        PH_HEX_LOW
    } phase_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    phase_t      phase_reg, phase_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] high_reg, high_next;
    logic [15:0] low_reg, low_next;
    logic [4:0]  hex;
    logic [15:0] high_shift;
    logic [15:0] low_shift;
    logic [20:0] pair_cp;

    // bit 4 flags a valid hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic jsu_pkg::group_t one_result(input logic [7:0] b, input logic has,
                                                   input logic done, input logic [3:0] err);
        jsu_pkg::group_t g;
        g.bytes    = '0;
        g.bytes[0] = b;
        g.count    = 3'd1;
        g.has_byte = has;
        g.done     = done;
        g.err      = err;
        return g;
    endfunction

    function automatic jsu_pkg::group_t encode(input logic [20:0] cp);
        jsu_pkg::group_t g;
        g.bytes    = '0;
        g.has_byte = 1'b1;
        g.done     = 1'b0;
        g.err      = jsu_pkg::ERR_NONE;
        if (cp < 21'h80)
        begin
            g.bytes[0] = cp[7:0];
            g.count    = 3'd1;
        end
        else if (cp < 21'h800)
        begin
            g.bytes[0] = 8'hC0 | {3'b0, cp[10:6]};
            g.bytes[1] = 8'h80 | {2'b0, cp[5:0]};
            g.count    = 3'd2;
        end
        else if (cp < 21'h10000)
        begin
            g.bytes[0] = 8'hE0 | {4'b0, cp[15:12]};
            g.bytes[1] = 8'h80 | {2'b0, cp[11:6]};
            g.bytes[2] = 8'h80 | {2'b0, cp[5:0]};
            g.count    = 3'd3;
        end
        else
        begin
            g.bytes[0] = 8'hF0 | {5'b0, cp[20:18]};
            g.bytes[1] = 8'h80 | {2'b0, cp[17:12]};
            g.bytes[2] = 8'h80 | {2'b0, cp[11:6]};
            g.bytes[3] = 8'h80 | {2'b0, cp[5:0]};
            g.count    = 3'd4;
        end
        return g;
    endfunction

    assign hex        = hex_value(data_byte);
    assign high_shift = {high_reg[11:0], hex[3:0]};
    assign low_shift  = {low_reg[11:0], hex[3:0]};
    assign pair_cp    = 21'h10000 + {1'b0, high_reg[9:0], low_shift[9:0]};

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        group      = '0;
        if (end_of_input)
        begin
            unique case (phase_reg)
                PH_ESC:      group = one_result(8'h00, 1'b0, 1'b0, jsu_pkg::ERR_ESC_END);
                PH_HEX_HIGH: group = one_result(8'h00, 1'b0, 1'b0, jsu_pkg::ERR_SHORT_UNI);
                PH_WANT_BSL, PH_WANT_U, PH_HEX_LOW:
                    group = one_result(8'h00, 1'b0, 1'b0, jsu_pkg::ERR_NO_LOW);
                default:     group = one_result(8'h00, 1'b0, 1'b0, jsu_pkg::ERR_UNTERMINATED);
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_ESC:
                begin
                    phase_next = PH_BODY;
                    case (data_byte)
                        CH_QUOTE, CH_BSL, CH_SLASH:
                            group = one_result(data_byte, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
                        CH_B: group = one_result(8'h08, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
                        CH_F: group = one_result(8'h0C, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
                        CH_N: group = one_result(8'h0A, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
                        CH_R: group = one_result(8'h0D, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
                        CH_T: group = one_result(8'h09, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
                        CH_U:
                        begin
                            phase_next = PH_HEX_HIGH;
                            cnt_next   = 2'd0;
                            high_next  = 16'd0;
                        end
                        default:
                            group = one_result(8'h00, 1'b0, 1'b0, jsu_pkg::ERR_BAD_ESC);
                    endcase
                end
                PH_HEX_HIGH:
                begin
                    if (!hex[4])
                        group = one_result(8'h00, 1'b0, 1'b0, jsu_pkg::ERR_BAD_HEX);
                    else
                    begin
                        high_next = high_shift;
                        if (cnt_reg != 2'd3)
                            cnt_next = 2'(cnt_reg + 2'd1);
                        else
                        begin
                            cnt_next = 2'd0;
                            // high surrogate waits for its partner
                            if (high_shift[15:10] == 6'b110110)
                                phase_next = PH_WANT_BSL;
                            else
                            begin
                                phase_next = PH_BODY;
                                group      = encode({5'b0, high_shift});
                            end
                        end
                    end
                end
                PH_WANT_BSL:
                begin
                    if (data_byte != CH_BSL)
                        group = one_result(8'h00, 1'b0, 1'b0, jsu_pkg::ERR_NO_LOW);
                    else
                        phase_next = PH_WANT_U;
                end
                PH_WANT_U:
                begin
                    if (data_byte != CH_U)
                        group = one_result(8'h00, 1'b0, 1'b0, jsu_pkg::ERR_NO_LOW);
                    else
                    begin
                        phase_next = PH_HEX_LOW;
                        cnt_next   = 2'd0;
                        low_next   = 16'd0;
                    end
                end
                PH_HEX_LOW:
                begin
                    if (!hex[4])
                        group = one_result(8'h00, 1'b0, 1'b0, jsu_pkg::ERR_BAD_LOW_HEX);
                    else if (cnt_reg != 2'd3)
                    begin
                        low_next = low_shift;
                        cnt_next = 2'(cnt_reg + 2'd1);
                    end
                    else if (low_shift[15:10] != 6'b110111)
                        group = one_result(8'h00, 1'b0, 1'b0, jsu_pkg::ERR_BAD_LOW);
                    else
                        group = encode(pair_cp);
                end
                default:
                begin
                    phase_next = PH_BODY;
                    if (data_byte == CH_QUOTE)
                        group = one_result(8'h00, 1'b0, 1'b1, jsu_pkg::ERR_NONE);
                    else if (data_byte == CH_BSL)
                        phase_next = PH_ESC;
                    else if (data_byte < 8'h20)
                        group = one_result(8'h00, 1'b0, 1'b0, jsu_pkg::ERR_CTRL_CHAR);
                    else
                        group = one_result(data_byte, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
                end
            endcase
        end
        // done, error or a finished pair starts a fresh string
        if (group.done || group.err != jsu_pkg::ERR_NONE ||
            (!end_of_input && phase_reg == PH_HEX_LOW && group.count != 3'd0))
        begin
            phase_next = PH_BODY;
            cnt_next   = 2'd0;
            high_next  = 16'd0;
            low_next   = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BODY;
            cnt_reg   <= 2'd0;
            high_reg  <= 16'd0;
            low_reg   <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
        end
    end

endmodule

@@ design/jsu_emit.sv @@
// result register that hands out a result group one item per cycle while the output is ready
module jsu_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  jsu_pkg::group_t  group,
    output logic             free,
    jsu_out_if.source        out_ch
);

    jsu_pkg::group_t grp_reg;
    logic [1:0]      idx_reg;
    logic            busy_reg;
    logic            at_last;
    logic            take;

    assign at_last = ({1'b0, idx_reg} == 3'(grp_reg.count - 3'd1));
    assign take    = busy_reg && out_ch.ready;
    assign free    = !busy_reg || (out_ch.ready && at_last);

    assign out_ch.valid       = busy_reg;
    assign out_ch.out_byte    = grp_reg.has_byte ? grp_reg.bytes[idx_reg] : 8'h00;
    assign out_ch.has_byte    = grp_reg.has_byte;
    assign out_ch.string_done = grp_reg.done;
    assign out_ch.error_code  = grp_reg.err;
    assign out_ch.last        = at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (load && group.count != 3'd0)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (take)
        begin
            if (at_last)
                busy_reg <= 1'b0;
            else
                idx_reg <= 2'(idx_reg + 2'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && group.count != 3'd0)
            grp_reg <= group;
    end

`ifndef SYNTHESIS
    // a new group only lands when the old one is gone or leaving
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && busy_reg) |-> (out_ch.ready && at_last))
        else $error("result group overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ({1'b0, idx_reg} < grp_reg.count))
        else $error("result index past group count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (grp_reg.done || grp_reg.err != jsu_pkg::ERR_NONE)) |-> at_last)
        else $error("done or error item not last");

    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && grp_reg.has_byte) |-> (!grp_reg.done && grp_reg.err == jsu_pkg::ERR_NONE))
        else $error("data byte mixed with done or error");
`endif

endmodule
